/* rtl/crc8_command_frame_receiver_macros.svh */
// Assertion macros for the command frame receiver
`ifndef CRC8_COMMAND_FRAME_RECEIVER_MACROS_SVH
`define CRC8_COMMAND_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every edge out of reset
`define CFR_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons must follow ante as a non-overlapping implication
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CFR_ASSERT_ALWAYS(label, clk, rst, expr)
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/crc8cfr_pkg.sv */
`timescale 1ns / 1ps

package crc8cfr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned STORE_DEPTH = 7;
   localparam int unsigned COUNT_W    = 3;
   localparam int unsigned CRC_BYTES  = 6;

   localparam logic [BYTE_W-1:0] BYTE_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_DEL  = 8'h7F;
   localparam logic [BYTE_W-1:0] BYTE_BS   = 8'h08;
   localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h31;

   localparam logic [COUNT_W-1:0] FRAME_LAST = 3'd7;
   localparam logic [COUNT_W-1:0] CRC_LAST   = 3'd5;

   localparam logic [BYTE_W-1:0] HEAD_RESET    = 8'h5A;
   localparam logic [BYTE_W-1:0] TAIL_RESET    = 8'hA5;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [BYTE_W-1:0] CODE_MIN_RESET = 8'h01;
   localparam logic [BYTE_W-1:0] CODE_MAX_RESET = 8'h04;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HEAD = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CRC  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TAIL = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CODE = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_ABORT    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_MAX = 3'd4;

   localparam logic [0:0] ACTION_BYTE = 1'b0;
   localparam logic [0:0] ACTION_TICK = 1'b1;

   // CRC-8, MSB first, one whole byte already folded into crc
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] value);
      logic [BYTE_W-1:0] crc;
      crc = value;
      for (int b = 0; b < BYTE_W; b++) begin
         if (crc[BYTE_W-1]) begin
            crc = {crc[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[BYTE_W-2:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

/* rtl/crc8_command_frame_receiver.sv */
// A byte or tick request that gives no result leaves the receiver idle, so it can take a new request in the next cycle.
// Abort and timeout results show in the cycle after the request is accepted.
// The eighth frame byte starts a check: the CRC state walks the six stored bytes through one byte-wide CRC unit,
// then the check state compares the frame and registers the result, which then shows in the output state.
// One request at a time: req_stall stays high until the result is taken.
// Synchronous active-high reset: frame empty, timer stopped, registers at defaults.
`timescale 1ns / 1ps
`include "crc8_command_frame_receiver_macros.svh"

module crc8_command_frame_receiver (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_action,
   input  logic [crc8cfr_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [crc8cfr_pkg::STATUS_W-1:0]       rsp_status,
   output logic [crc8cfr_pkg::BYTE_W-1:0]         rsp_command_code,
   output logic [crc8cfr_pkg::BYTE_W-1:0]         rsp_data_b0,
   output logic [crc8cfr_pkg::BYTE_W-1:0]         rsp_data_b1,
   output logic [crc8cfr_pkg::BYTE_W-1:0]         rsp_data_b2,
   output logic [crc8cfr_pkg::BYTE_W-1:0]         rsp_data_b3,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [crc8cfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crc8cfr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import crc8cfr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CRC   = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [BYTE_W-1:0] head_ff, tail_cfg_ff, code_min_ff, code_max_ff;
   logic [TICK_W-1:0] timeout_ff;

   logic [BYTE_W-1:0]  store_ff [STORE_DEPTH];
   logic               store_we;
   logic [COUNT_W-1:0] store_idx;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               timer_ff, timer_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  tick_next;
   logic [BYTE_W-1:0]  tail_ff, tail_in;
   logic [BYTE_W-1:0]  crc_ff, crc_in;
   logic [COUNT_W-1:0] crc_idx_ff, crc_idx_in;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0]   out_ff [5];
   logic [BYTE_W-1:0]   out_in [5];

   logic req_take;
   logic [STATUS_W-1:0] check_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign tick_next = tick_ff + 1'b1;

   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_status       = status_ff;
   assign rsp_command_code = out_ff[0];
   assign rsp_data_b0      = out_ff[1];
   assign rsp_data_b1      = out_ff[2];
   assign rsp_data_b2      = out_ff[3];
   assign rsp_data_b3      = out_ff[4];

   // frame checks in priority order: head, crc, tail, code range
   always_comb begin
      if (store_ff[0] != head_ff) begin
         check_status = STATUS_BAD_HEAD;
      end else if (crc_ff != store_ff[6]) begin
         check_status = STATUS_BAD_CRC;
      end else if (tail_ff != tail_cfg_ff) begin
         check_status = STATUS_BAD_TAIL;
      end else if (store_ff[1] < code_min_ff || store_ff[1] > code_max_ff) begin
         check_status = STATUS_BAD_CODE;
      end else begin
         check_status = STATUS_OK;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      timer_in   = timer_ff;
      tick_in    = tick_ff;
      tail_in    = tail_ff;
      crc_in     = crc_ff;
      crc_idx_in = crc_idx_ff;
      status_in  = status_ff;
      for (int i = 0; i < 5; i++) begin
         out_in[i] = out_ff[i];
      end
      store_we  = 1'b0;
      store_idx = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACTION_TICK) begin
                  if (timer_ff) begin
                     tick_in = tick_next;
                     if (tick_next == timeout_ff) begin
                        state_in  = ST_OUT;
                        status_in = STATUS_ABORT;
                        for (int i = 0; i < 5; i++) begin
                           out_in[i] = '0;
                        end
                        count_in = '0;
                        timer_in = 1'b0;
                        tick_in  = '0;
                     end
                  end
               end else if (req_rx_byte == BYTE_CR) begin
                  state_in  = ST_OUT;
                  status_in = STATUS_ABORT;
                  for (int i = 0; i < 5; i++) begin
                     out_in[i] = '0;
                  end
                  count_in = '0;
                  timer_in = 1'b0;
                  tick_in  = '0;
               end else if (req_rx_byte == BYTE_DEL || req_rx_byte == BYTE_BS) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end else if (count_ff != FRAME_LAST) begin
                  store_we = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     timer_in = 1'b1;
                     tick_in  = '0;
                  end
               end else begin
                  // tail byte: walk the stored bytes ahead of the CRC byte through the CRC unit
                  tail_in    = req_rx_byte;
                  crc_in     = '0;
                  crc_idx_in = '0;
                  state_in   = ST_CRC;
               end
            end
         end
         ST_CRC: begin
            crc_in     = crc8_byte(crc_ff ^ store_ff[crc_idx_ff]);
            crc_idx_in = crc_idx_ff + 1'b1;
            if (crc_idx_ff == CRC_LAST) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            status_in = check_status;
            for (int i = 0; i < 5; i++) begin
               out_in[i] = store_ff[i+1];
            end
            count_in = '0;
            timer_in = 1'b0;
            tick_in  = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         timer_ff    <= 1'b0;
         tick_ff     <= '0;
         head_ff     <= HEAD_RESET;
         tail_cfg_ff <= TAIL_RESET;
         timeout_ff  <= TIMEOUT_RESET;
         code_min_ff <= CODE_MIN_RESET;
         code_max_ff <= CODE_MAX_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         timer_ff <= timer_in;
         tick_ff  <= tick_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_HEAD:     head_ff     <= csr_data[BYTE_W-1:0];
               CSR_TAIL:     tail_cfg_ff <= csr_data[BYTE_W-1:0];
               CSR_TIMEOUT:  timeout_ff  <= csr_data[TICK_W-1:0];
               CSR_CODE_MIN: code_min_ff <= csr_data[BYTE_W-1:0];
               CSR_CODE_MAX: code_max_ff <= csr_data[BYTE_W-1:0];
               default: begin
                  // drop writes beyond the register list
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tail_ff    <= tail_in;
      crc_ff     <= crc_in;
      crc_idx_ff <= crc_idx_in;
      status_ff  <= status_in;
      for (int i = 0; i < 5; i++) begin
         out_ff[i] <= out_in[i];
      end
      if (store_we) begin
         store_ff[store_idx] <= req_rx_byte;
      end
   end

   `CFR_ASSERT_ALWAYS(a_tick_idle_when_stopped, clock, reset, timer_ff || (tick_ff == '0))
   `CFR_ASSERT_ALWAYS(a_crc_index_range, clock, reset, (state_ff != ST_CRC) || (crc_idx_ff <= CRC_LAST))
   `CFR_ASSERT_ALWAYS(a_abort_fields_zero, clock, reset, !(rsp_valid && rsp_status == STATUS_ABORT) || (rsp_command_code == '0 && rsp_data_b0 == '0 && rsp_data_b1 == '0 && rsp_data_b2 == '0 && rsp_data_b3 == '0))
   `CFR_ASSERT_NEXT(a_frame_cleared_after_check, clock, reset, state_ff == ST_CHECK, rsp_valid && count_ff == '0 && !timer_ff)

endmodule

/* verif/tb_crc8_command_frame_receiver.sv */
`timescale 1ns / 1ps

module tb_crc8_command_frame_receiver;
   import crc8cfr_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   code;
      logic [BYTE_W-1:0]   d0;
      logic [BYTE_W-1:0]   d1;
      logic [BYTE_W-1:0]   d2;
      logic [BYTE_W-1:0]   d3;
   } frame_rsp_type;

   typedef struct packed {
      logic [0:0]          act;
      logic [BYTE_W-1:0]   rx;
      logic                crc_fill;
      logic                typed;
      logic [STATUS_W-1:0] status;
   } stim_row_type;

   localparam int DIR_ROWS = 25;
   localparam int CHECK_GAP = 12;
   localparam int PHASE_ITEMS = 210;

   localparam int FLAW_HEAD  = 0;
   localparam int FLAW_CRC   = 1;
   localparam int FLAW_TAIL  = 2;
   localparam int FLAW_CODE  = 3;
   localparam int FLAW_ABORT = 4;
   localparam int FLAW_ERASE = 5;
   localparam int FLAW_STALL = 6;

   // typed status only on rows whose outcome is plain; code and data are zero there
   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ACTION_BYTE, BYTE_CR,  1'b0, 1'b1, STATUS_ABORT},
      '{ACTION_BYTE, BYTE_BS,  1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, BYTE_DEL, 1'b0, 1'b0, STATUS_OK},
      '{ACTION_TICK, 8'hFF,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h5A,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h04,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_TICK, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'hFF,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h80,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, BYTE_DEL, 1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h81,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h01,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b1, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'hA5,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, BYTE_CR,  1'b0, 1'b1, STATUS_ABORT},
      '{ACTION_BYTE, 8'hFF,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'h00,    1'b0, 1'b0, STATUS_OK},
      '{ACTION_BYTE, 8'hFF,    1'b0, 1'b1, STATUS_BAD_HEAD}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = ACTION_BYTE;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [BYTE_W-1:0]     rsp_command_code;
   logic [BYTE_W-1:0]     rsp_data_b0;
   logic [BYTE_W-1:0]     rsp_data_b1;
   logic [BYTE_W-1:0]     rsp_data_b2;
   logic [BYTE_W-1:0]     rsp_data_b3;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // receiver-side model state and registers
   logic [BYTE_W-1:0]  cfg_head;
   logic [BYTE_W-1:0]  cfg_tail;
   logic [TICK_W-1:0]  cfg_timeout;
   logic [BYTE_W-1:0]  cfg_lo;
   logic [BYTE_W-1:0]  cfg_hi;
   logic [BYTE_W-1:0]  rx_store [STORE_DEPTH];
   logic [COUNT_W-1:0] rx_count;
   logic               timer_on;
   logic [TICK_W-1:0]  tick_cnt;

   frame_rsp_type frame_status_q [$];
   int         fault_count = 0;
   int         frame_items = 0;
   int         snd_idle_pct = 0;
   int         rcv_idle_pct = 0;

   crc8_command_frame_receiver DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_command_code (rsp_command_code),
      .rsp_data_b0      (rsp_data_b0),
      .rsp_data_b1      (rsp_data_b1),
      .rsp_data_b2      (rsp_data_b2),
      .rsp_data_b3      (rsp_data_b3),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_500_000;
      $display("crc8_command_frame_receiver test failed");
      $finish;
   end

   function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] d);
      logic [BYTE_W-1:0] c;
      c = crc ^ d;
      for (int b = 0; b < BYTE_W; b++) begin
         c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] stored_crc();
      logic [BYTE_W-1:0] c;
      c = '0;
      for (int i = 0; i < CRC_BYTES; i++) begin
         c = crc8_next(c, rx_store[i]);
      end
      return c;
   endfunction

   task automatic clear_frame();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         rx_store[i] = '0;
      end
      rx_count = '0;
      timer_on = 1'b0;
      tick_cnt = '0;
   endtask

   task automatic frame_rx_predict(input logic act, input logic [BYTE_W-1:0] b,
                                   output bit has_rsp, output frame_rsp_type r);
      logic [BYTE_W-1:0] crc;
      has_rsp = 1'b0;
      r = '0;
      if (act == ACTION_TICK) begin
         if (timer_on) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt == cfg_timeout) begin
               clear_frame();
               has_rsp = 1'b1;
               r.status = STATUS_ABORT;
            end
         end
      end else if (b == BYTE_CR) begin
         clear_frame();
         has_rsp = 1'b1;
         r.status = STATUS_ABORT;
      end else if (b == BYTE_BS || b == BYTE_DEL) begin
         if (rx_count != 0) rx_count = rx_count - 3'd1;
      end else if (rx_count < FRAME_LAST) begin
         rx_store[rx_count] = b;
         rx_count = rx_count + 3'd1;
         if (rx_count == 3'd1) begin
            timer_on = 1'b1;
            tick_cnt = '0;
         end
      end else begin
         crc = stored_crc();
         has_rsp = 1'b1;
         r.code = rx_store[1];
         r.d0 = rx_store[2];
         r.d1 = rx_store[3];
         r.d2 = rx_store[4];
         r.d3 = rx_store[5];
         if (rx_store[0] != cfg_head) r.status = STATUS_BAD_HEAD;
         else if (crc != rx_store[6]) r.status = STATUS_BAD_CRC;
         else if (b != cfg_tail) r.status = STATUS_BAD_TAIL;
         else if (rx_store[1] < cfg_lo || rx_store[1] > cfg_hi) r.status = STATUS_BAD_CODE;
         else r.status = STATUS_OK;
         clear_frame();
      end
   endtask

   // valid stays high after acceptance; the next call or the caller lowers it
   task automatic send_req(input logic act, input logic [BYTE_W-1:0] b,
                           input bit use_typed = 1'b0,
                           input logic [STATUS_W-1:0] typed_st = STATUS_OK);
      bit            has_rsp;
      frame_rsp_type r;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (!((act == ACTION_TICK && !timer_on) ||
            (act == ACTION_BYTE && (b == BYTE_BS || b == BYTE_DEL) && rx_count == 0)))
         frame_items++;
      frame_rx_predict(act, b, has_rsp, r);
      if (use_typed) begin
         has_rsp = 1'b1;
         r = '0;
         r.status = typed_st;
      end
      if (has_rsp) frame_status_q.push_back(r);
   endtask

   task automatic load_regs(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] t,
                            input logic [TICK_W-1:0] to, input logic [BYTE_W-1:0] lo,
                            input logic [BYTE_W-1:0] hi);
      logic [CSR_DATA_W-1:0] vals [5];
      logic [CSR_IDX_W-1:0]  idx [5];
      int                    i;
      vals = '{16'(h), 16'(t), 16'(to), 16'(lo), 16'(hi)};
      idx = '{CSR_HEAD, CSR_TAIL, CSR_TIMEOUT, CSR_CODE_MIN, CSR_CODE_MAX};
      i = 0;
      csr_valid <= 1'b1;
      csr_index <= idx[0];
      csr_data <= vals[0];
      while (i < 5) begin
         @(posedge clock);
         if (csr_ready === 1'b1) begin
            case (idx[i])
               CSR_HEAD:     cfg_head = vals[i][BYTE_W-1:0];
               CSR_TAIL:     cfg_tail = vals[i][BYTE_W-1:0];
               CSR_TIMEOUT:  cfg_timeout = vals[i][TICK_W-1:0];
               CSR_CODE_MIN: cfg_lo = vals[i][BYTE_W-1:0];
               CSR_CODE_MAX: cfg_hi = vals[i][BYTE_W-1:0];
               default: ;
            endcase
            i++;
            if (i < 5) begin
               csr_index <= idx[i];
               csr_data <= vals[i];
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (frame_status_q.size() != 0) @(posedge clock);
      repeat (CHECK_GAP) @(posedge clock);
   endtask

   // well-formed frame with random content, sometimes broken on purpose
   task automatic send_frame();
      logic [BYTE_W-1:0] fb [8];
      logic [BYTE_W-1:0] crc;
      int                flaw;
      int                pos;
      int                nt;
      flaw = $urandom_range(0, 11);
      pos = $urandom_range(0, 7);
      fb[0] = cfg_head;
      fb[1] = 8'($urandom_range(cfg_lo, cfg_hi));
      for (int i = 2; i < 6; i++) fb[i] = 8'($urandom);
      if (flaw == FLAW_CODE) fb[1] = 8'($urandom);
      if (flaw == FLAW_HEAD) fb[0] = cfg_head ^ 8'($urandom_range(1, 255));
      crc = '0;
      for (int i = 0; i < 6; i++) crc = crc8_next(crc, fb[i]);
      fb[6] = (flaw == FLAW_CRC) ? (crc ^ 8'($urandom_range(1, 255))) : crc;
      fb[7] = (flaw == FLAW_TAIL) ? (cfg_tail ^ 8'($urandom_range(1, 255))) : cfg_tail;
      for (int i = 0; i < 8; i++) begin
         if (i == pos) begin
            case (flaw)
               FLAW_ABORT: begin
                  send_req(ACTION_BYTE, BYTE_CR);
                  return;
               end
               FLAW_ERASE: begin
                  send_req(ACTION_BYTE, 8'($urandom));
                  send_req(ACTION_BYTE, ($urandom_range(0, 1) != 0) ? BYTE_BS : BYTE_DEL);
               end
               FLAW_STALL: begin
                  nt = (cfg_timeout <= 48) ? int'(cfg_timeout) : $urandom_range(1, 8);
                  repeat (nt) send_req(ACTION_TICK, 8'($urandom));
               end
               default: ;
            endcase
         end
         if ($urandom_range(0, 99) < 6) send_req(ACTION_TICK, 8'($urandom));
         send_req(ACTION_BYTE, fb[i]);
      end
   endtask

   always @(posedge clock) begin
      frame_rsp_type want;
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (frame_status_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected response: status %0d code %h data %h %h %h %h",
                        rsp_status, rsp_command_code, rsp_data_b0, rsp_data_b1,
                        rsp_data_b2, rsp_data_b3);
         end else begin
            want = frame_status_q.pop_front();
            if (rsp_status !== want.status || rsp_command_code !== want.code ||
                rsp_data_b0 !== want.d0 || rsp_data_b1 !== want.d1 ||
                rsp_data_b2 !== want.d2 || rsp_data_b3 !== want.d3) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch: expected status %0d code %h data %h %h %h %h",
                           want.status, want.code, want.d0, want.d1, want.d2, want.d3);
                  $display("          got      status %0d code %h data %h %h %h %h",
                           rsp_status, rsp_command_code, rsp_data_b0, rsp_data_b1,
                           rsp_data_b2, rsp_data_b3);
               end
            end
         end
      end
   end

   initial begin
      stim_row_type      row;
      logic [BYTE_W-1:0] b;
      int                target;
      cfg_head = HEAD_RESET;
      cfg_tail = TAIL_RESET;
      cfg_timeout = TIMEOUT_RESET;
      cfg_lo = CODE_MIN_RESET;
      cfg_hi = CODE_MAX_RESET;
      clear_frame();
      snd_idle_pct = 21;
      rcv_idle_pct = 46;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed pass at reset register values
      for (int n = 0; n < DIR_ROWS; n++) begin
         row = DIR_TABLE[n];
         b = row.crc_fill ? stored_crc() : row.rx;
         send_req(row.act, b, row.typed, row.status);
      end
      req_valid <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         snd_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 46 : 0;
         rcv_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 21 : 0;
         case (ph)
            0: load_regs(HEAD_RESET, TAIL_RESET, TIMEOUT_RESET, CODE_MIN_RESET,
                         CODE_MAX_RESET);
            1: load_regs(8'h00, 8'hFF, 16'd1, 8'h00, 8'hFF);
            2: load_regs(8'hFF, 8'h00, 16'hFFFF, 8'hFF, 8'h00);
            3: load_regs(8'h31, BYTE_CR, 16'd5, 8'h10, 8'h20);
            default: load_regs(8'($urandom), 8'($urandom), 16'($urandom_range(1, 40)),
                               8'($urandom_range(0, 127)), 8'($urandom_range(64, 255)));
         endcase
         target = frame_items + PHASE_ITEMS;
         while (frame_items < target) begin
            if ($urandom_range(0, 99) < 85) send_frame();
            else send_req(1'($urandom_range(0, 1)), 8'($urandom));
         end
         // empty the frame before the registers change
         send_req(ACTION_BYTE, BYTE_CR);
         req_valid <= 1'b0;
      end

      wait_drained();
      if (frame_status_q.size() != 0) begin
         fault_count++;
         $display("%0d expected responses never arrived", frame_status_q.size());
      end
      if (fault_count == 0) begin
         $display("crc8_command_frame_receiver test passed");
      end else begin
         $display("crc8_command_frame_receiver test failed");
      end
      $finish;
   end

endmodule

/* crc8_command_frame_receiver.f */
+incdir+rtl
rtl/crc8cfr_pkg.sv
rtl/crc8_command_frame_receiver.sv
verif/tb_crc8_command_frame_receiver.sv
